>>> src/lsmp_pkg.sv
// shared types, constants and tables of the scan point projection
`timescale 1ns / 1ps
`default_nettype none
package lsmp_pkg;

    localparam int MAX_BEAMS         = 1024;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int IDX_W   = 12;
    localparam int CFG_W   = 24;
    localparam int CFGA_W  = 3;
    localparam int TRIG_W  = 26;
    localparam int CXY_W   = 34;
    localparam int CZ_W    = 33;
    localparam int ITER_W  = 5;
    localparam int MA_W    = 32;
    localparam int MB_W    = 27;
    localparam int MP_W    = MA_W + MB_W;

    localparam logic [CFGA_W-1:0] REG_PPM   = 3'd0;
    localparam logic [CFGA_W-1:0] REG_START = 3'd1;
    localparam logic [CFGA_W-1:0] REG_STEP  = 3'd2;
    localparam logic [CFGA_W-1:0] REG_ROLL  = 3'd3;
    localparam logic [CFGA_W-1:0] REG_POSEX = 3'd4;
    localparam logic [CFGA_W-1:0] REG_POSEY = 3'd5;
    localparam logic [CFGA_W-1:0] REG_HEAD  = 3'd6;

    localparam logic signed [MB_W-1:0] DEG2RAD_Q30 = 27'sd18740374;
    localparam logic signed [MB_W-1:0] RECIP_2PI   = 27'sd2670175;
    localparam logic signed [MB_W-1:0] TWO_PI_B    = 27'sd411775;
    localparam logic signed [MB_W-1:0] LEVER_Q16   = 27'sd19661;
    localparam int RECIP_SH = 40;

    localparam logic [19:0] TWO_PI_Q16  = 20'd411775;
    localparam logic [19:0] PI_Q16      = 20'd205887;
    localparam logic [19:0] HALF_PI_Q16 = 20'd102944;
    localparam logic [19:0] FOLD_HI     = 20'd308831;
    localparam logic signed [31:0] ANG_BIAS = 32'sd421657600;

    localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic                   start;
        logic signed [CZ_W-1:0] z;
        logic                   neg;
    } t_cord_req;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_cord_rsp;

    function automatic logic [30:0] atan_q30(input logic [ITER_W-1:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd843314856;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043836;
            5'd3:  v = 31'd133525158;
            5'd4:  v = 31'd67021686;
            5'd5:  v = 31'd33543515;
            5'd6:  v = 31'd16775850;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194282;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048575;
            5'd11: v = 31'd524287;
            5'd12: v = 31'd262143;
            5'd13: v = 31'd131071;
            5'd14: v = 31'd65535;
            5'd15: v = 31'd32767;
            5'd16: v = 31'd16383;
            5'd17: v = 31'd8191;
            5'd18: v = 31'd4095;
            5'd19: v = 31'd2047;
            5'd20: v = 31'd1023;
            5'd21: v = 31'd511;
            5'd22: v = 31'd255;
            5'd23: v = 31'd127;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> src/lsmp_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module lsmp_mul
    import lsmp_pkg::*;
(
    input  wire                     i_clk,
    input  wire signed [MA_W-1:0]   i_a,
    input  wire signed [MB_W-1:0]   i_b,
    output logic signed [MP_W-1:0]  o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule
`default_nettype wire

>>> src/lsmp_cordic.sv
// iterative rotation cordic, one micro-rotation per cycle
`timescale 1ns / 1ps
`default_nettype none
module lsmp_cordic
    import lsmp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cord_req  i_req,
    output t_cord_rsp  o_rsp
);

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [ITER_W-1:0]        r_i, n_i;
    logic signed [CXY_W-1:0]  r_x, n_x, r_y, n_y;
    logic signed [CZ_W-1:0]   r_z, n_z;
    logic                     r_neg, n_neg;
    logic signed [TRIG_W-1:0] r_cos, n_cos, r_sin, n_sin;

    logic signed [CXY_W-1:0]  xs, ys, xf, yf, xr, yr;
    logic signed [CZ_W-1:0]   at;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = $signed({2'b00, atan_q30(r_i)});
        xf = r_neg ? -r_x : r_x;
        yf = r_neg ? -r_y : r_y;
        xr = (xf + 34'sd32) >>> 6;
        yr = (yf + 34'sd32) >>> 6;
        n_busy = r_busy;
        n_done = 1'b0;
        n_i    = r_i;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_neg  = r_neg;
        n_cos  = r_cos;
        n_sin  = r_sin;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_i    = '0;
            n_x    = CORDIC_GAIN;
            n_y    = '0;
            n_z    = i_req.z;
            n_neg  = i_req.neg;
        end else if (r_busy) begin
            if (r_i == ITER_W'(CORDIC_ITERATIONS)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_cos  = xr[TRIG_W-1:0];
                n_sin  = yr[TRIG_W-1:0];
            end else begin
                if (!r_z[CZ_W-1]) begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - at;
                end else begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + at;
                end
                n_i = r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_i   <= n_i;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_neg <= n_neg;
        r_cos <= n_cos;
        r_sin <= n_sin;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.cos_v = r_cos;
    assign o_rsp.sin_v = r_sin;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("cordic done without a running rotation");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy && r_i == '0)
        else $error("cordic start not taken");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_i <= ITER_W'(CORDIC_ITERATIONS))
        else $error("cordic iteration count overrun");

endmodule
`default_nettype wire

>>> src/lidar_scan_to_map_points.sv
// laser range samples to saturated map points, sequenced over one multiplier and one cordic
// sequence per request: two cordic passes, two angle reductions, eight partial products on one multiplier
// one request at a time; the input is not ready while one is in work
// a finished point waits in the output register; the next request can be taken meanwhile
// reset (synchronous, active low) loads the register defaults and clears the beam index
`timescale 1ns / 1ps
`default_nettype none
module lidar_scan_to_map_points
    import lsmp_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [CFGA_W-1:0]  i_cfg_idx,
    input  wire [CFG_W-1:0]   i_cfg_data,
    input  wire               i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire [15:0]        i_s_axis_tdata,  // range_m[15:0]
    input  wire               i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire               i_m_axis_tready,
    output logic [47:0]       o_m_axis_tdata,  // point_x[23:0], point_y[47:24]
    output logic              o_m_axis_tlast
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MHEAD = 4'd1;
    localparam logic [3:0] S_MOFF  = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_R1    = 4'd4;
    localparam logic [3:0] S_R2    = 4'd5;
    localparam logic [3:0] S_R3    = 4'd6;
    localparam logic [3:0] S_R4    = 4'd7;
    localparam logic [3:0] S_CORD  = 4'd8;
    localparam logic [3:0] S_PRNG  = 4'd9;
    localparam logic [3:0] S_PLEV  = 4'd10;
    localparam logic [3:0] S_MAC   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [19:0] r_ppm, r_start, r_roll;
    logic [15:0] r_step;
    logic [23:0] r_posex, r_posey;
    logic [16:0] r_head;

    logic [3:0]               r_state;
    logic [IDX_W-1:0]         r_idx;
    logic [15:0]              r_range;
    logic                     r_last;
    logic signed [21:0]       r_hrad;
    logic signed [31:0]       r_t;
    logic [19:0]              r_rm;
    logic                     r_pass;
    logic signed [TRIG_W-1:0] r_ct, r_st, r_ch, r_sh;
    logic [35:0]              r_p;
    logic [34:0]              r_lev;
    logic [3:0]               r_k;
    logic                     r_pv, r_rv;
    logic [2:0]               r_pk, r_rk;
    logic signed [63:0]       r_acc, r_pair;
    logic signed [26:0]       r_sx, r_sy;
    logic                     r_ovalid;
    logic [47:0]              r_odata;
    logic                     r_olast;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   prod;
    t_cord_req                cd_req;
    t_cord_rsp                cd_rsp;

    logic                     s_acc, out_free;
    logic signed [20:0]       roll_s;
    logic                     roll_up;
    logic signed [29:0]       off;
    logic signed [31:0]       total;
    logic [19:0]              r1;
    logic signed [19:0]       fold;
    logic                     fold_neg;
    logic [2:0]               k3;
    logic signed [TRIG_W-1:0] trig;
    logic signed [63:0]       prod64, acc_new, rnd;
    logic [IDX_W:0]           idx_inc;
    logic [23:0]              satx, saty;

    lsmp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    lsmp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cd_req),
        .o_rsp   (cd_rsp)
    );

    function automatic logic [23:0] sat24(input logic signed [26:0] v);
        logic [23:0] r;
        if (v > 27'sd8388607)
            r = 24'h7FFFFF;
        else if (v < -27'sd8388608)
            r = 24'h800000;
        else
            r = v[23:0];
        return r;
    endfunction

    always_comb begin
        s_acc    = i_s_axis_tvalid && o_s_axis_tready;
        out_free = !r_ovalid || i_m_axis_tready;
        roll_s   = $signed({r_roll[19], r_roll});
        roll_up  = (roll_s >= 21'sd102944) || (roll_s <= -21'sd102944);
        off      = $signed({{10{r_start[19]}}, r_start}) + $signed({2'b00, prod[27:0]});
        total    = roll_up ? 32'(r_hrad) + 32'(off) : 32'(r_hrad) - 32'(off);
        r1       = (r_rm >= TWO_PI_Q16) ? r_rm - TWO_PI_Q16 : r_rm;
        if (r1 <= HALF_PI_Q16) begin
            fold     = $signed(r1);
            fold_neg = 1'b0;
        end else if (r1 <= PI_Q16) begin
            fold     = $signed(r1 - PI_Q16);
            fold_neg = 1'b1;
        end else if (r1 < FOLD_HI) begin
            // negative side folds by one more than pi
            fold     = $signed(r1 - PI_Q16 - 20'd1);
            fold_neg = 1'b1;
        end else begin
            fold     = $signed(r1 - TWO_PI_Q16);
            fold_neg = 1'b0;
        end
        cd_req.start = (r_state == S_R4);
        cd_req.z     = $signed({fold[18:0], 14'd0});
        cd_req.neg   = fold_neg;

        k3 = r_k[2:0];
        case (k3[2:1])
            2'b00:   trig = r_ct;
            2'b01:   trig = r_ch;
            2'b10:   trig = r_st;
            default: trig = r_sh;
        endcase

        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MHEAD: begin
                mul_a = MA_W'($signed(r_head));
                mul_b = DEG2RAD_Q30;
            end
            S_MOFF: begin
                mul_a = $signed({16'd0, r_step});
                mul_b = $signed({15'd0, r_idx});
            end
            S_R1: begin
                mul_a = r_t;
                mul_b = RECIP_2PI;
            end
            S_R2: begin
                mul_a = $signed({20'd0, prod[RECIP_SH+11:RECIP_SH]});
                mul_b = TWO_PI_B;
            end
            S_PRNG: begin
                mul_a = $signed({16'd0, r_range});
                mul_b = $signed({7'd0, r_ppm});
            end
            S_PLEV: begin
                mul_a = $signed({12'd0, r_ppm});
                mul_b = LEVER_Q16;
            end
            S_MAC: begin
                if (!r_k[3]) begin
                    case (k3[1:0])
                        2'b00:   mul_a = $signed({14'd0, r_p[17:0]});
                        2'b01:   mul_a = $signed({14'd0, r_p[35:18]});
                        2'b10:   mul_a = $signed({14'd0, r_lev[17:0]});
                        default: mul_a = $signed({15'd0, r_lev[34:18]});
                    endcase
                    mul_b = MB_W'(trig);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        prod64  = 64'(prod);
        acc_new = r_pk[0] ? r_acc + (prod64 <<< 18) : prod64;
        rnd     = r_rk[1] ? (r_pair + (64'sd1 <<< 43)) >>> 44
                          : (r_pair + (64'sd1 <<< 37)) >>> 38;
        idx_inc = {1'b0, r_idx} + 1'b1;
        satx    = sat24(r_sx);
        saty    = sat24(r_sy);
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppm    <= 20'd5120;
            r_start  <= 20'd320269;
            r_step   <= 16'd572;
            r_roll   <= '0;
            r_posex  <= '0;
            r_posey  <= '0;
            r_head   <= '0;
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
            r_rv     <= 1'b0;
            r_k      <= '0;
            r_pass   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PPM:   r_ppm   <= i_cfg_data[19:0];
                    REG_START: r_start <= i_cfg_data[19:0];
                    REG_STEP:  r_step  <= i_cfg_data[15:0];
                    REG_ROLL:  r_roll  <= i_cfg_data[19:0];
                    REG_POSEX: r_posex <= i_cfg_data[23:0];
                    REG_POSEY: r_posey <= i_cfg_data[23:0];
                    REG_HEAD:  r_head  <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_m_axis_tready)
                r_ovalid <= 1'b0;
            r_pv <= 1'b0;
            r_rv <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_range <= i_s_axis_tdata;
                        r_last  <= i_s_axis_tlast;
                        r_state <= S_MHEAD;
                    end
                end
                S_MHEAD: r_state <= S_MOFF;
                S_MOFF: begin
                    r_hrad  <= 22'((prod + (MP_W'(1) <<< 20)) >>> 21);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_t     <= total + ANG_BIAS;
                    r_pass  <= 1'b0;
                    r_state <= S_R1;
                end
                S_R1: r_state <= S_R2;
                S_R2: r_state <= S_R3;
                S_R3: begin
                    r_rm    <= r_t[19:0] - prod[19:0];
                    r_state <= S_R4;
                end
                S_R4: r_state <= S_CORD;
                S_CORD: begin
                    if (cd_rsp.done) begin
                        if (!r_pass) begin
                            r_ct    <= cd_rsp.cos_v;
                            r_st    <= cd_rsp.sin_v;
                            r_pass  <= 1'b1;
                            r_t     <= 32'(r_hrad) + ANG_BIAS;
                            r_state <= S_R1;
                        end else begin
                            r_ch    <= cd_rsp.cos_v;
                            r_sh    <= cd_rsp.sin_v;
                            r_state <= S_PRNG;
                        end
                    end
                end
                S_PRNG: r_state <= S_PLEV;
                S_PLEV: begin
                    r_p     <= prod[35:0];
                    r_sx    <= 27'($signed(r_posex));
                    r_sy    <= 27'($signed(r_posey));
                    r_k     <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_k == 4'd0)
                        r_lev <= prod[34:0];
                    if (!r_k[3]) begin
                        r_k  <= r_k + 1'b1;
                        r_pv <= 1'b1;
                        r_pk <= k3;
                    end
                    if (r_pv) begin
                        r_acc <= acc_new;
                        if (r_pk[0]) begin
                            r_pair <= acc_new;
                            r_rv   <= 1'b1;
                            r_rk   <= r_pk;
                        end
                    end
                    if (r_rv) begin
                        if (r_rk[2])
                            r_sy <= r_sy + rnd[26:0];
                        else
                            r_sx <= r_sx + rnd[26:0];
                    end
                    if (r_k[3] && !r_pv && !r_rv)
                        r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {saty, satx};
                        r_olast  <= r_last;
                        if (r_last || idx_inc >= (IDX_W+1)'(MAX_BEAMS))
                            r_idx <= '0;
                        else
                            r_idx <= idx_inc[IDX_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("request taken while a sample is in work");

    a_done_in_cord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cd_rsp.done |-> r_state == S_CORD)
        else $error("cordic result outside its wait state");

    a_index_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free && r_last) |=> r_idx == '0)
        else $error("beam index not cleared after last beam");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> o_m_axis_tvalid)
        else $error("finished point not presented");

endmodule
`default_nettype wire

>>> test/tb.sv
// testbench of the scan point projection: directed rows and random scans checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import lsmp_pkg::*;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic               plast;
    } t_point;

    typedef struct {
        logic [15:0]        rng;
        logic               lst;
        logic               known;
        logic signed [23:0] ex;
        logic signed [23:0] ey;
    } t_row;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFGA_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_valid = 1'b0;
    logic [15:0]       s_data = '0;
    logic              s_last = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [47:0]       m_data;
    logic              m_last;

    lidar_scan_to_map_points u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // predictor state
    longint unsigned regs[7];
    int              beam_idx;
    t_point          pending_points[$];
    int              errors = 0;
    bit              quiet = 1'b0;
    longint          cycles = 0;

    localparam int REG_WIDTH[7] = '{20, 20, 16, 20, 24, 24, 17};
    localparam longint ATAN_TAB[24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    function automatic longint sx(input longint unsigned v, input int w);
        logic signed [63:0] t;
        t = v << (64 - w);
        return t >>> (64 - w);
    endfunction

    function automatic longint rnd_hu(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint sat24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    // rotation cordic on a q16 angle, cos and sin out in q24
    task automatic rotate(input longint ang, output longint c, output longint s);
        longint r, x, y, z, nx;
        bit     flip;
        r = ang % 411775;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (r < 0) r += 411775;
        if (r > 205887) r -= 411775;
        if (r > 102944) begin
            r -= 205887;
            flip = 1'b1;
        end else if (r < -102944) begin
            r += 205887;
            flip = 1'b1;
        end
        z = r * 16384;
        for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_TAB[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_TAB[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = rnd_hu(x, 6);
        s = rnd_hu(y, 6);
    endtask

    task automatic project_beam(input logic [15:0] rng, input logic lst, output t_point pt);
        longint ppm, hrad, offs, roll, total, ct, st, ch, sh, p, lev;
        ppm  = regs[0];
        hrad = rnd_hu(sx(regs[6], 17) * 18740374, 21);
        offs = sx(regs[1], 20) + longint'(regs[2]) * beam_idx;
        roll = sx(regs[3], 20);
        total = (roll >= 102944 || roll <= -102944) ? hrad + offs : hrad - offs;
        rotate(total, ct, st);
        rotate(hrad, ch, sh);
        p   = longint'(rng) * ppm;
        lev = 19661 * ppm;
        pt.px = sat24(sx(regs[4], 24) + rnd_hu(p * ct, 38) + rnd_hu(lev * ch, 44));
        pt.py = sat24(sx(regs[5], 24) + rnd_hu(p * st, 38) + rnd_hu(lev * sh, 44));
        pt.plast = lst;
        if (lst || beam_idx + 1 >= MAX_BEAMS) beam_idx = 0;
        else beam_idx = beam_idx + 1;
    endtask

    task automatic wr(input logic [CFGA_W-1:0] idx, input longint unsigned val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_W-1:0];
        regs[idx] = val & ((64'd1 << REG_WIDTH[idx]) - 1);
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_points.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic setup(input longint unsigned ppm, input longint unsigned st_ang,
                         input longint unsigned stp, input longint unsigned roll,
                         input longint unsigned pxv, input longint unsigned pyv,
                         input longint unsigned hd);
        drain();
        wr(REG_PPM, ppm);
        wr(REG_START, st_ang);
        wr(REG_STEP, stp);
        wr(REG_ROLL, roll);
        wr(REG_POSEX, pxv);
        wr(REG_POSEY, pyv);
        wr(REG_HEAD, hd);
        cfg_we <= 1'b0;
    endtask

    // returns with the request accepted at the current edge
    task automatic send_beam(input logic [15:0] rng, input logic lst, input t_row row);
        t_point pt;
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= rng;
        s_last  <= lst;
        do @(posedge clk); while (!s_ready);
        project_beam(rng, lst, pt);
        if (row.known) begin
            pt.px = row.ex;
            pt.py = row.ey;
        end
        pending_points.push_back(pt);
    endtask

    task automatic beam(input logic [15:0] rng, input logic lst);
        t_row none;
        none.known = 1'b0;
        send_beam(rng, lst, none);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic longint unsigned rnd_bits(input int w);
        return {$urandom, $urandom} & ((64'd1 << w) - 1);
    endfunction

    // output sink with stall bursts
    initial begin
        int b;
        @(posedge clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                b = $urandom_range(1, 10);
            end else begin
                m_ready <= 1'b1;
                b = $urandom_range(1, 20);
            end
            repeat (b) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        t_point e;
        if (rst_n && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $error("point with no request pending");
                errors++;
            end else begin
                e = pending_points.pop_front();
                if ($signed(m_data[23:0]) !== e.px) begin
                    $error("point_x expected %0d actual %0d", e.px, $signed(m_data[23:0]));
                    errors++;
                end
                if ($signed(m_data[47:24]) !== e.py) begin
                    $error("point_y expected %0d actual %0d", e.py, $signed(m_data[47:24]));
                    errors++;
                end
                if (m_last !== e.plast) begin
                    $error("point_last expected %0d actual %0d", e.plast, m_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("lidar_scan_to_map_points: mismatch");
            $finish;
        end
    end

    t_row dir_rows[] = '{
        '{16'd0,     1'b0, 1'b0, 24'sd0, 24'sd0},
        '{16'hFFFF,  1'b0, 1'b0, 24'sd0, 24'sd0},
        '{16'd1,     1'b0, 1'b0, 24'sd0, 24'sd0},
        '{16'h8000,  1'b0, 1'b0, 24'sd0, 24'sd0},
        '{16'h5555,  1'b0, 1'b0, 24'sd0, 24'sd0},
        '{16'hAAAA,  1'b1, 1'b0, 24'sd0, 24'sd0},
        '{16'd1024,  1'b0, 1'b0, 24'sd0, 24'sd0},
        '{16'd5120,  1'b1, 1'b0, 24'sd0, 24'sd0},
        '{16'hFFFF,  1'b1, 1'b0, 24'sd0, 24'sd0}
    };

    // zero scale: every point is the pose
    t_row zero_rows[] = '{
        '{16'hFFFF,  1'b0, 1'b1, 24'sh123456, -24'sd5},
        '{16'h0000,  1'b0, 1'b1, 24'sh123456, -24'sd5},
        '{16'h7FFF,  1'b1, 1'b1, 24'sh123456, -24'sd5}
    };

    initial begin
        int n, len;
        regs = '{5120, 320269, 572, 0, 0, 0, 0};
        beam_idx = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        foreach (dir_rows[i]) send_beam(dir_rows[i].rng, dir_rows[i].lst, dir_rows[i]);
        stop_sending();

        setup(0, 1000, 300, 0, 24'h123456, 24'hFFFFFB, 5000);
        foreach (zero_rows[i]) send_beam(zero_rows[i].rng, zero_rows[i].lst, zero_rows[i]);
        stop_sending();

        // extremes: large scale and pose near the rails, upside-down roll limits
        setup(20'hFFFFF, 20'h7FFFF, 16'hFFFF, 102944, 24'h7FFFFF, 24'h800000, 46080);
        foreach (dir_rows[i]) beam(dir_rows[i].rng, dir_rows[i].lst);
        stop_sending();
        setup(20'hFFFFF, 20'h80000, 16'hFFFF, 20'hFFFFF & -102944, 24'h800000, 24'h7FFFFF,
              17'h1FFFF & -46080);
        for (int i = 0; i < 5; i++) beam(16'hFFFF, i == 4);
        stop_sending();
        setup(1, 0, 0, 102943, 0, 0, 0);
        beam(16'hFFFF, 1'b0);
        beam(16'd0, 1'b1);
        stop_sending();

        // random settings, scans of random length with random ranges and random last flags
        n = 0;
        while (n < 760) begin
            if ($urandom_range(0, 4) == 0)
                setup(rnd_bits(20), rnd_bits(20), rnd_bits(16), rnd_bits(20),
                      rnd_bits(24), rnd_bits(24), rnd_bits(17));
            else
                setup($urandom_range(1, 12000), rnd_bits(24), rnd_bits(24),
                      $urandom_range(0, 1) ? rnd_bits(24) : $urandom_range(0, 1000),
                      rnd_bits(24) >> $urandom_range(0, 23), rnd_bits(24),
                      sx($urandom_range(0, 92160), 64) - 46080);
            for (int k = 0; k < 4; k++) begin
                len = $urandom_range(1, 40);
                for (int j = 0; j < len; j++) begin
                    if (n >= 700) quiet = 1'b1;
                    beam(($urandom_range(0, 7) == 0) ? rnd_bits(16) : $urandom_range(0, 20000),
                         (j == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 30) == 0));
                    n++;
                end
            end
            stop_sending();
        end

        drain();
        if (errors == 0) begin
            $display("lidar_scan_to_map_points: match");
        end else begin
            $display("lidar_scan_to_map_points: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
